>>> design/hpdc_pkg.sv
// Package for the HDMI PLL divider calculation block.
// Holds register indexes, mode codes, constants and the pipeline types.
// No dependencies.
`timescale 1ns / 1ps

package hpdc_pkg;

    localparam logic [7:0] REG_REF_CLOCK = 8'd0;
    localparam logic [7:0] REG_PREDIV_N  = 8'd1;
    localparam logic [7:0] REG_POST_M2   = 8'd2;
    localparam logic [7:0] REG_DEEP_MODE = 8'd3;

    localparam logic [1:0] MODE_24BIT = 2'd0;
    localparam logic [1:0] MODE_30BIT = 2'd1;
    localparam logic [1:0] MODE_36BIT = 2'd2;

    localparam logic [19:0] UNSUPPORTED_PIXEL_KHZ = 20'd148500;
    localparam logic [20:0] DCO_RANGE_LIMIT_KHZ   = 21'd100000;
    localparam logic [15:0] RECIP_TEN             = 16'd52429; // ceil(2^19 / 10)
    localparam logic [11:0] SD_STEP_KHZ           = 12'd2500;  // 250 times the final /10
    localparam logic [18:0] SD_SAT_LIMIT          = 19'd2560;

    localparam int MAIN_STEPS = 32;
    localparam int FRAC_STEPS = 18;
    localparam int CHAIN_LEN  = MAIN_STEPS + 1 + FRAC_STEPS;

    typedef struct packed {
        logic [15:0] clk;
        logic [8:0]  np1;
        logic [6:0]  m2;
        logic [1:0]  mode;
        logic [12:0] clk10;
        logic [19:0] sd_div;
    } cfg_t;

    typedef struct packed {
        logic        unsup;
        logic [20:0] phy;
        logic [31:0] num;
        logic [15:0] rem;
        logic [31:0] quo;
        logic [17:0] mf;
        logic [17:0] sdnum;
        logic [19:0] sdrem;
        logic [17:0] sdq;
    } stage_t;

endpackage

>>> design/hpdc_if.sv
// Channel interfaces of the HDMI PLL divider calculation block.
// Depends on nothing but the port widths of the block.
`timescale 1ns / 1ps

interface hpdc_pix_if;
    logic        valid;
    logic        ready;
    logic [19:0] pixel_clock_khz;
    modport source (output valid, output pixel_clock_khz, input ready);
    modport sink (input valid, input pixel_clock_khz, output ready);
endinterface

interface hpdc_res_if;
    logic        valid;
    logic        ready;
    logic        unsupported;
    logic [20:0] phy_clock_khz;
    logic [15:0] multiplier_m;
    logic [17:0] fraction_mf;
    logic        dco_high_range;
    logic [7:0]  sigma_delta_divider;
    logic [6:0]  post_divider_copy;
    modport source (output valid, output unsupported, output phy_clock_khz,
                    output multiplier_m, output fraction_mf, output dco_high_range,
                    output sigma_delta_divider, output post_divider_copy, input ready);
    modport sink (input valid, input unsupported, input phy_clock_khz,
                  input multiplier_m, input fraction_mf, input dco_high_range,
                  input sigma_delta_divider, input post_divider_copy, output ready);
endinterface

interface hpdc_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/hpdc_cfg_regs.sv
// Configuration registers and the divisors derived from them.
// Depends on hpdc_pkg and hpdc_cfg_if.
`timescale 1ns / 1ps

module hpdc_cfg_regs
    import hpdc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hpdc_cfg_if.sink   cfg,
    output cfg_t       cfg_out
);

    logic [15:0] ref_reg;
    logic [7:0]  prediv_reg;
    logic [6:0]  m2_reg;
    logic [1:0]  mode_reg;
    logic [12:0] clk10_reg;
    logic [19:0] sd_div_reg;
    logic [15:0] clk_fix;
    logic [31:0] clk10_prod;
    logic [8:0]  np1;

    assign cfg.ready  = 1'b1;
    assign clk_fix    = (ref_reg == 16'd0) ? 16'd1 : ref_reg;
    assign np1        = {1'b0, prediv_reg} + 9'd1;
    assign clk10_prod = clk_fix * RECIP_TEN;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg    <= 16'd38400;
            prediv_reg <= 8'd0;
            m2_reg     <= 7'd1;
            mode_reg   <= MODE_24BIT;
            clk10_reg  <= 13'd3840;
            sd_div_reg <= 20'd2500;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_REF_CLOCK: ref_reg    <= cfg.data;
                    REG_PREDIV_N:  prediv_reg <= cfg.data[7:0];
                    REG_POST_M2:   m2_reg     <= cfg.data[6:0];
                    REG_DEEP_MODE: mode_reg   <= cfg.data[1:0];
                    default:       ;
                endcase
            end
            // Derived divisors are registered, so they follow the registers in the next cycle.
            clk10_reg  <= clk10_prod[31:19];
            sd_div_reg <= 20'(np1 * SD_STEP_KHZ);
        end
    end

    assign cfg_out.clk    = clk_fix;
    assign cfg_out.np1    = np1;
    assign cfg_out.m2     = m2_reg;
    assign cfg_out.mode   = mode_reg;
    assign cfg_out.clk10  = clk10_reg;
    assign cfg_out.sd_div = sd_div_reg;

endmodule

>>> design/hpdc_front.sv
// Front stages: input capture, deep color scaling and the dividend 10*phy*(N+1).
// Depends on hpdc_pkg.
`timescale 1ns / 1ps

module hpdc_front
    import hpdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [19:0] pix,
    input  cfg_t        cfg_in,
    output logic        out_valid,
    output stage_t      out_stage
);

    logic        vld0_reg;
    logic [19:0] pix_reg;
    logic        vld1_reg;
    stage_t      st_reg;
    stage_t      st_next;
    logic [22:0] pix5;
    logic [21:0] pix3;
    logic [24:0] phy10;

    assign pix5 = {3'b0, pix_reg} + {1'b0, pix_reg, 2'b0};
    assign pix3 = {2'b0, pix_reg} + {1'b0, pix_reg, 1'b0};

    always_comb
    begin
        st_next = '0;
        case (cfg_in.mode)
            MODE_30BIT: st_next.phy = pix5[22:2];
            MODE_36BIT:
            begin
                if (pix_reg == UNSUPPORTED_PIXEL_KHZ)
                    st_next.unsup = 1'b1;
                else
                    st_next.phy = pix3[21:1];
            end
            default:    st_next.phy = {1'b0, pix_reg};
        endcase
        phy10 = {4'b0, st_next.phy} * 25'd10;
        st_next.num = 32'(phy10 * cfg_in.np1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
        end
        else if (en)
        begin
            vld0_reg <= in_valid;
            vld1_reg <= vld0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix_reg <= pix;
            st_reg  <= st_next;
        end
    end

    assign out_valid = vld1_reg;
    assign out_stage = st_reg;

endmodule

>>> design/hpdc_divchain.sv
// Pipelined restoring divider chain: 32 quotient bits of M, then the 18 fraction
// bits of MF beside the sigma-delta division. Depends on hpdc_pkg.
`timescale 1ns / 1ps

module hpdc_divchain
    import hpdc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  stage_t in_stage,
    input  cfg_t   cfg_in,
    output logic   out_valid,
    output stage_t out_stage
);

    logic   vld_reg [CHAIN_LEN];
    stage_t st_reg  [CHAIN_LEN];
    stage_t st_next [CHAIN_LEN];

    for (genvar k = 0; k < CHAIN_LEN; k++)
    begin : g_step
        stage_t      prev;
        logic        prev_vld;
        logic [16:0] trial;
        logic        ge;
        logic [20:0] sd_trial;
        logic        sd_ge;
        logic [15:0] msat;
        logic [28:0] prod;

        if (k == 0)
        begin : g_first
            assign prev     = in_stage;
            assign prev_vld = in_valid;
        end
        else
        begin : g_rest
            assign prev     = st_reg[k-1];
            assign prev_vld = vld_reg[k-1];
        end

        always_comb
        begin
            st_next[k] = prev;
            trial      = '0;
            ge         = 1'b0;
            sd_trial   = '0;
            sd_ge      = 1'b0;
            msat       = '0;
            prod       = '0;
            if (k < MAIN_STEPS)
            begin
                trial = {prev.rem, prev.num[31]};
                ge    = trial >= {1'b0, cfg_in.clk};
                st_next[k].rem = ge ? 16'(trial - {1'b0, cfg_in.clk}) : trial[15:0];
                st_next[k].quo = {prev.quo[30:0], ge};
                st_next[k].num = {prev.num[30:0], 1'b0};
            end
            else if (k == MAIN_STEPS)
            begin
                // M saturates here; the sigma-delta dividend uses the saturated M.
                msat = (prev.quo[31:16] != 16'd0) ? 16'hFFFF : prev.quo[15:0];
                prod = msat * cfg_in.clk10;
                st_next[k].quo   = {16'd0, msat};
                st_next[k].sdrem = {9'd0, prod[28:18]};
                st_next[k].sdnum = prod[17:0];
                st_next[k].sdq   = '0;
            end
            else
            begin
                trial = {prev.rem, 1'b0};
                ge    = trial >= {1'b0, cfg_in.clk};
                st_next[k].rem = ge ? 16'(trial - {1'b0, cfg_in.clk}) : trial[15:0];
                st_next[k].mf  = {prev.mf[16:0], ge};
                sd_trial = {prev.sdrem, prev.sdnum[17]};
                sd_ge    = sd_trial >= {1'b0, cfg_in.sd_div};
                st_next[k].sdrem = sd_ge ? 20'(sd_trial - {1'b0, cfg_in.sd_div})
                                         : sd_trial[19:0];
                st_next[k].sdq   = {prev.sdq[16:0], sd_ge};
                st_next[k].sdnum = {prev.sdnum[16:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= prev_vld;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                st_reg[k] <= st_next[k];
        end
    end

    assign out_valid = vld_reg[CHAIN_LEN-1];
    assign out_stage = st_reg[CHAIN_LEN-1];

endmodule

>>> design/hpdc_out.sv
// Output register: sigma-delta rounding and saturation, masking of unsupported items.
// Depends on hpdc_pkg and hpdc_res_if.
`timescale 1ns / 1ps

module hpdc_out
    import hpdc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  stage_t     in_stage,
    input  cfg_t       cfg_in,
    hpdc_res_if.source result
);

    logic        vld_reg;
    logic        unsup_reg;
    logic [20:0] phy_reg;
    logic [15:0] m_reg;
    logic [17:0] mf_reg;
    logic        dco_reg;
    logic [7:0]  sd_reg;
    logic [6:0]  m2_reg;
    logic [18:0] sd_round;
    logic [27:0] sd_prod;
    logic [7:0]  sd_val;
    logic        u;

    assign u        = in_stage.unsup;
    assign sd_round = {1'b0, in_stage.sdq} + 19'd5;
    assign sd_prod  = sd_round[11:0] * RECIP_TEN;
    assign sd_val   = (sd_round >= SD_SAT_LIMIT) ? 8'hFF : sd_prod[26:19];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unsup_reg <= u;
            phy_reg   <= u ? 21'd0 : in_stage.phy;
            m_reg     <= u ? 16'd0 : in_stage.quo[15:0];
            mf_reg    <= u ? 18'd0 : in_stage.mf;
            dco_reg   <= !u && (in_stage.phy > DCO_RANGE_LIMIT_KHZ);
            sd_reg    <= u ? 8'd0 : sd_val;
            m2_reg    <= u ? 7'd0 : cfg_in.m2;
        end
    end

    assign result.valid               = vld_reg;
    assign result.unsupported         = unsup_reg;
    assign result.phy_clock_khz       = phy_reg;
    assign result.multiplier_m        = m_reg;
    assign result.fraction_mf         = mf_reg;
    assign result.dco_high_range      = dco_reg;
    assign result.sigma_delta_divider = sd_reg;
    assign result.post_divider_copy   = m2_reg;

endmodule

>>> design/hdmi_pll_divider_calc_top.sv
// Channel    Direction  Contents
// pixel      in         pixel_clock_khz
// result     out        unsupported, phy, M, MF, DCO range, sigma-delta divider, M2
// cfg        in         register index and data, always ready
//
// An item passes 54 register stages: the front stages, the divider chain and the output
// register; one item is taken per cycle while the pipeline is not held. Most stages
// belong to the restoring divider chain: one quotient bit per stage, 32 for M, one
// saturation stage and 18 more for MF and the sigma-delta divider.
// The whole pipeline holds while a result waits; reset empties it.
// Depends on hpdc_pkg, the interfaces, hpdc_cfg_regs, hpdc_front, hpdc_divchain, hpdc_out.
`timescale 1ns / 1ps

module hdmi_pll_divider_calc_top
    import hpdc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hpdc_pix_if.sink   pixel,
    hpdc_res_if.source result,
    hpdc_cfg_if.sink   cfg
);

    cfg_t   cfg_vals;
    logic   en;
    logic   front_valid;
    stage_t front_stage;
    logic   chain_valid;
    stage_t chain_stage;

    // The pipeline moves whenever the output register is empty or being taken.
    assign en          = !result.valid || result.ready;
    assign pixel.ready = en;

    hpdc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_vals)
    );

    hpdc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pixel.valid),
        .pix       (pixel.pixel_clock_khz),
        .cfg_in    (cfg_vals),
        .out_valid (front_valid),
        .out_stage (front_stage)
    );

    hpdc_divchain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_stage  (front_stage),
        .cfg_in    (cfg_vals),
        .out_valid (chain_valid),
        .out_stage (chain_stage)
    );

    hpdc_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (chain_valid),
        .in_stage (chain_stage),
        .cfg_in   (cfg_vals),
        .result   (result)
    );

endmodule
